[hw/rtl/a2s_pkg.sv]
// Package for the axis-to-spherical parameter block: payload structs,
// register indexes, status codes, CORDIC widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
package a2s_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 18;
    localparam int DOT_W         = 34;
    localparam int CW            = 38;
    localparam int AW            = ANGLE_BITS + 2;

    localparam logic [2:0] REG_POLE = 3'd0;
    localparam logic [2:0] REG_SEAM = 3'd1;
    localparam logic [2:0] REG_UMIN = 3'd2;
    localparam logic [2:0] REG_UMAX = 3'd3;
    localparam logic [2:0] REG_VMIN = 3'd4;
    localparam logic [2:0] REG_VMAX = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [31:0] GAIN_INV = 32'h26DD3B6A;

    typedef struct packed {
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
        logic signed [15:0] ref_r0_x;
        logic signed [15:0] ref_r0_y;
        logic signed [15:0] ref_r0_z;
        logic signed [15:0] ref_r1_x;
        logic signed [15:0] ref_r1_y;
        logic signed [15:0] ref_r1_z;
        logic signed [15:0] ref_r2_x;
        logic signed [15:0] ref_r2_y;
        logic signed [15:0] ref_r2_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] param_u;
        logic signed [15:0] param_v;
        logic        [1:0]  status;
    } out_item_t;

    function automatic logic [31:0] atan_turn32(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
                3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
                9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
                15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
                21: t = 32'h00000146; 22: t = 32'h000000A3; default: t = 32'h00000051;
            endcase
            atan_turn32 = t;
        end
    endfunction

    // Table angle rounded half up to ANGLE_BITS per turn.
    function automatic logic signed [AW-1:0] table_angle(input int i);
        logic [32:0] t;
        begin
            t = {1'b0, atan_turn32(i)};
            if (ANGLE_BITS < 32)
                t = (t + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
            table_angle = AW'(signed'(t));
        end
    endfunction

    function automatic logic [2:0] canon_axis(input logic [2:0] a);
        canon_axis = (a > 3'd5) ? a - 3'd3 : a;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/a2s_cordic.sv]
// Pipelined CORDIC vectoring unit, one stage per iteration, with stall.
// Depends on a2s_pkg.
`timescale 1ns / 1ps
`default_nettype none
module a2s_cordic
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   advance,
    input  wire logic                                   in_valid,
    input  wire logic signed [a2s_pkg::CW-1:0]          in_x,
    input  wire logic signed [a2s_pkg::CW-1:0]          in_y,
    input  wire logic signed [a2s_pkg::AW-1:0]          in_a,
    input  wire logic [63:0]                            in_side,
    output logic                                        out_valid,
    output logic signed [a2s_pkg::CW-1:0]               out_x,
    output logic signed [a2s_pkg::AW-1:0]               out_a,
    output logic [63:0]                                 out_side
);
    import a2s_pkg::*;

    logic                 v_reg [CORDIC_STAGES];
    logic signed [CW-1:0] x_reg [CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES];
    logic signed [AW-1:0] a_reg [CORDIC_STAGES];
    logic [63:0]          s_reg [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic                 v_in;
        logic signed [CW-1:0] x_in, y_in;
        logic signed [AW-1:0] a_in;
        logic [63:0]          s_in;
        logic signed [CW-1:0] x_next, y_next;
        logic signed [AW-1:0] a_next;
        if (i == 0)
        begin : g_head
            assign v_in = in_valid;
            assign x_in = in_x;
            assign y_in = in_y;
            assign a_in = in_a;
            assign s_in = in_side;
        end
        else
        begin : g_tail
            assign v_in = v_reg[i-1];
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign a_in = a_reg[i-1];
            assign s_in = s_reg[i-1];
        end
        always_comb
        begin
            if (!y_in[CW-1])
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                a_next = a_in + table_angle(i);
            end
            else
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                a_next = a_in - table_angle(i);
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (advance)
                v_reg[i] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                a_reg[i] <= a_next;
                s_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STAGES-1];
    assign out_x     = x_reg[CORDIC_STAGES-1];
    assign out_a     = a_reg[CORDIC_STAGES-1];
    assign out_side  = s_reg[CORDIC_STAGES-1];

endmodule
`default_nettype wire

[hw/rtl/axis_to_spherical_params.sv]
// Top level: axis vector to spherical U/V parameters.
// Throughput: one item per clock; the whole pipeline holds while the output waits.
// Reset clears valid bits and loads the register defaults (pole +X, seam +Y,
// U range 0..4.0, V range 0..2.0).
// Depends on a2s_pkg and a2s_cordic.
`timescale 1ns / 1ps
`default_nettype none
module axis_to_spherical_params
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire a2s_pkg::in_item_t    in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output a2s_pkg::out_item_t        out_data,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import a2s_pkg::*;

    localparam logic signed [AW-1:0] HALF    = AW'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (ANGLE_BITS - 2);

    logic [2:0] pole_reg, seam_reg;
    logic signed [15:0] umin_reg, umax_reg, vmin_reg, vmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_reg <= 3'd0; seam_reg <= 3'd1;
            umin_reg <= 16'sd0; umax_reg <= 16'sd1024;
            vmin_reg <= 16'sd0; vmax_reg <= 16'sd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLE: pole_reg <= cfg_data[2:0];
                REG_SEAM: seam_reg <= cfg_data[2:0];
                REG_UMIN: umin_reg <= cfg_data;
                REG_UMAX: umax_reg <= cfg_data;
                REG_VMIN: vmin_reg <= cfg_data;
                REG_VMAX: vmax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // Axis decode (the user must keep config static while items are in flight; the block does not enforce it).
    logic [2:0] p_ax, s_ax;
    logic [1:0] pa, sa, la;
    logic       p_neg, s_pos, same;
    always_comb
    begin
        p_ax  = canon_axis(pole_reg);
        s_ax  = canon_axis(seam_reg);
        same  = (p_ax == s_ax);
        p_neg = p_ax >= 3'd3;
        s_pos = s_ax >= 3'd3;
        pa    = p_neg ? 2'(p_ax - 3'd3) : p_ax[1:0];
        sa    = s_pos ? 2'(s_ax - 3'd3) : s_ax[1:0];
        case (3'(pa) + 3'(sa))
            3'd0: la = 2'd0; 3'd1: la = 2'd2; 3'd2: la = 2'd1;
            3'd3: la = 2'd0; 3'd4: la = 2'd2; default: la = 2'd1;
        endcase
    end

    // Stage 1: nine products.
    logic s1_v_reg;
    logic signed [31:0] pr_reg [3][3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_v_reg <= 1'b0;
        else if (advance) s1_v_reg <= in_valid;
    end
    logic signed [15:0] vin [3];
    logic signed [15:0] rin [3][3];
    assign vin = '{in_data.vec_x, in_data.vec_y, in_data.vec_z};
    assign rin = '{'{in_data.ref_r0_x, in_data.ref_r0_y, in_data.ref_r0_z},
                   '{in_data.ref_r1_x, in_data.ref_r1_y, in_data.ref_r1_z},
                   '{in_data.ref_r2_x, in_data.ref_r2_y, in_data.ref_r2_z}};
    always_ff @(posedge clk)
    begin
        if (advance)
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    pr_reg[i][j] <= vin[j] * rin[i][j];
    end

    // Stage 2: dot products, apply signs, pick local axes.
    logic s2_v_reg;
    logic signed [DOT_W-1:0] lx_reg, ly_reg, lz_reg;
    logic signed [DOT_W-1:0] t [3];
    logic signed [DOT_W-1:0] lx_n, ly_n, lz_n;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            t[i] = DOT_W'(pr_reg[i][0]) + DOT_W'(pr_reg[i][1]) + DOT_W'(pr_reg[i][2]);
        // pole sign applied twice on pole and last axes cancels; once remains on seam
        lx_n = (p_neg ^ !s_pos) ? -t[sa] : t[sa];
        ly_n = !s_pos ? -t[la] : t[la];
        lz_n = t[pa];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_v_reg <= 1'b0;
        else if (advance) s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lx_reg <= lx_n; ly_reg <= ly_n; lz_reg <= lz_n;
        end
    end

    // Stage 3: status and prerotation into the right half plane.
    logic s3_v_reg;
    logic [1:0] s3_st_reg;
    logic signed [CW-1:0] c1x_reg, c1y_reg, lz3_reg;
    logic signed [AW-1:0] c1a_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s3_v_reg <= 1'b0;
        else if (advance) s3_v_reg <= s2_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (same) s3_st_reg <= ST_SAME;
            else if (lx_reg == '0 && ly_reg == '0 && lz_reg == '0) s3_st_reg <= ST_ZERO;
            else s3_st_reg <= ST_OK;
            if (lx_reg[DOT_W-1])
            begin
                c1x_reg <= -CW'(lx_reg); c1y_reg <= -CW'(ly_reg); c1a_reg <= HALF;
            end
            else
            begin
                c1x_reg <= CW'(lx_reg); c1y_reg <= CW'(ly_reg); c1a_reg <= '0;
            end
            lz3_reg <= CW'(lz_reg);
        end
    end

    logic c1_v;
    logic signed [CW-1:0] c1_mag;
    logic signed [AW-1:0] c1_ang;
    logic [63:0] c1_side;
    a2s_cordic u_cordic_phi
    (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(s3_v_reg), .in_x(c1x_reg), .in_y(c1y_reg), .in_a(c1a_reg),
        .in_side({24'd0, s3_st_reg, lz3_reg}),
        .out_valid(c1_v), .out_x(c1_mag), .out_a(c1_ang), .out_side(c1_side)
    );

    // Stage 4: gain correction of the magnitude.
    logic s4_v_reg;
    logic [69:0] r_prod_reg;
    logic [ANGLE_BITS-1:0] phi4_reg;
    logic [39:0] side4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s4_v_reg <= 1'b0;
        else if (advance) s4_v_reg <= c1_v;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_prod_reg <= 70'(unsigned'(c1_mag)) * 70'(GAIN_INV);
            phi4_reg   <= ANGLE_BITS'(c1_ang + HALF);
            side4_reg  <= c1_side[39:0];
        end
    end

    // Stage 5: prerotation for theta.
    logic s5_v_reg;
    logic signed [CW-1:0] c2x_reg, c2y_reg;
    logic signed [AW-1:0] c2a_reg;
    logic signed [CW-1:0] r_val, lz4;
    assign r_val = CW'(r_prod_reg >> 30);
    assign lz4   = side4_reg[CW-1:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s5_v_reg <= 1'b0;
        else if (advance) s5_v_reg <= s4_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (lz4[CW-1])
            begin
                c2x_reg <= r_val; c2y_reg <= -lz4; c2a_reg <= QUARTER;
            end
            else
            begin
                c2x_reg <= lz4; c2y_reg <= r_val; c2a_reg <= '0;
            end
        end
    end
    logic [ANGLE_BITS-1:0] phi5_reg;
    logic [1:0] st5_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            phi5_reg <= phi4_reg;
            st5_reg  <= side4_reg[CW+1:CW];
        end
    end

    logic c2_v;
    logic signed [CW-1:0] c2_mag;
    logic signed [AW-1:0] c2_ang;
    logic [63:0] c2_side;
    a2s_cordic u_cordic_theta
    (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(s5_v_reg), .in_x(c2x_reg), .in_y(c2y_reg), .in_a(c2a_reg),
        .in_side({44'd0, st5_reg, phi5_reg}),
        .out_valid(c2_v), .out_x(c2_mag), .out_a(c2_ang), .out_side(c2_side)
    );

    // Stage 6: clamp theta, range products.
    logic s6_v_reg;
    logic signed [ANGLE_BITS+17:0] up_reg, vp_reg;
    logic [1:0] st6_reg;
    logic signed [AW-1:0] th;
    always_comb
    begin
        th = c2_ang;
        if (th < 0) th = '0;
        if (th > HALF) th = HALF;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s6_v_reg <= 1'b0;
        else if (advance) s6_v_reg <= c2_v;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            up_reg  <= (17'(umax_reg) - 17'(umin_reg))
                       * $signed({1'b0, c2_side[ANGLE_BITS-1:0]});
            vp_reg  <= (17'(vmax_reg) - 17'(vmin_reg)) * $signed({1'b0, th[ANGLE_BITS-1:0]});
            st6_reg <= c2_side[ANGLE_BITS+1:ANGLE_BITS];
        end
    end

    // Stage 7: round, offset, saturate into the output register; U and V are zero unless status is OK.
    logic signed [19:0] u_sum, v_sum;
    logic signed [15:0] u_sat, v_sat;
    always_comb
    begin
        u_sum = 20'(umin_reg) + 20'((up_reg + (ANGLE_BITS+18)'(HALF)) >>> ANGLE_BITS);
        v_sum = 20'(vmin_reg) + 20'((vp_reg + (ANGLE_BITS+18)'(QUARTER)) >>> (ANGLE_BITS-1));
        u_sat = (u_sum > 20'sd32767) ? 16'sh7FFF : (u_sum < -20'sd32768) ? 16'sh8000 : 16'(u_sum);
        v_sat = (v_sum > 20'sd32767) ? 16'sh7FFF : (v_sum < -20'sd32768) ? 16'sh8000 : 16'(v_sum);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid <= 1'b0;
        else if (advance) out_valid <= s6_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data.status  <= st6_reg;
            out_data.param_u <= (st6_reg == ST_OK) ? u_sat : 16'sd0;
            out_data.param_v <= (st6_reg == ST_OK) ? v_sat : 16'sd0;
        end
    end

endmodule
`default_nettype wire
